// File: rtl/assert_macros.svh
// assertion macros used by the rtl file that carries checks
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: rtl/hugt_pkg.sv
// shared types, codes and tables for the hash unique group table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hugt_pkg;

  localparam int HASH_W  = 32;
  localparam int ROW_W   = 20;
  localparam int GIDX_W  = 10;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int TBITS_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  localparam logic [TBITS_W-1:0] TBITS_RESET = 4'd10;
  localparam logic [TBITS_W-1:0] TBITS_MIN   = 4'd2;

  localparam logic [7:0] POLY_SLACK [32] = '{
    8'd0,  8'd0,  8'd3,  8'd3,  8'd3,  8'd5,  8'd3,  8'd3,
    8'd29, 8'd17, 8'd9,  8'd5,  8'd83, 8'd27, 8'd43, 8'd3,
    8'd45, 8'd9,  8'd39, 8'd39, 8'd9,  8'd5,  8'd3,  8'd33,
    8'd27, 8'd9,  8'd71, 8'd39, 8'd9,  8'd5,  8'd83, 8'd0
  };

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [GIDX_W-1:0] group_index;
    logic [ROW_W-1:0]  group_row;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/hugt_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hugt_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/hugt_ctrl.sv
// probe sequencer: accepts items, walks the slot and group memories, clears slots
// depends on hugt_pkg
`timescale 1ns / 1ps
`default_nettype none

module hugt_ctrl #(
  parameter int SLOT_BITS = 10,
  parameter int KEY_WIDTH = 64,
  parameter int GRP_W     = 116
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [hugt_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [hugt_pkg::HASH_W-1:0]         in_hash,
  input  wire logic [KEY_WIDTH-1:0]                in_key,
  input  wire logic [hugt_pkg::ROW_W-1:0]          in_row,
  input  wire logic [hugt_pkg::TBITS_W-1:0]        table_bits,
  input  wire logic                                out_free,
  output logic                                     res_load,
  output hugt_pkg::result_t                        res,
  output logic                                     slot_rd_en,
  output logic [SLOT_BITS-1:0]                     slot_rd_addr,
  input  wire logic [SLOT_BITS-1:0]                slot_rd_data,
  output logic                                     slot_wr_en,
  output logic [SLOT_BITS-1:0]                     slot_wr_addr,
  output logic [SLOT_BITS-1:0]                     slot_wr_data,
  output logic                                     grp_rd_en,
  output logic [SLOT_BITS-1:0]                     grp_rd_addr,
  input  wire logic [GRP_W-1:0]                    grp_rd_data,
  output logic                                     grp_wr_en,
  output logic [SLOT_BITS-1:0]                     grp_wr_addr,
  output logic [GRP_W-1:0]                         grp_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_PROBE, S_SLOT, S_GROUP, S_DONE
  } state_t;

  localparam int SW = SLOT_BITS;
  localparam int RW = hugt_pkg::ROW_W;
  localparam int HW = hugt_pkg::HASH_W;

  state_t state_r, state_nxt;
  logic   clr_reply_r, clr_reply_nxt;
  logic [SW-1:0] sweep_r, sweep_nxt;
  logic [SW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] probe_r, probe_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [SW:0]   visits_r, visits_nxt;
  logic [SW:0]   size_r, size_nxt;
  logic [SW-1:0] mask_r, mask_nxt;
  logic [SW:0]   poly_r, poly_nxt;
  logic [SW-1:0] g_r, g_nxt;
  logic [hugt_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [HW-1:0] hash_r, hash_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [RW-1:0] row_r, row_nxt;
  hugt_pkg::result_t res_r, res_nxt;

  // size, mask and first probe from the incoming item
  logic [hugt_pkg::TBITS_W-1:0] bits_eff;
  logic [SW:0]   size_in;
  logic [SW-1:0] mask_in;
  logic [SW:0]   poly_in;
  logic [HW-1:0] mixed_in;
  logic [SW-1:0] step_raw;
  logic [SW-1:0] step_in;
  logic [SW-1:0] probe_in;

  function automatic logic [hugt_pkg::GIDX_W-1:0] gidx(input logic [SW-1:0] g);
    logic [31:0] gx;
    gx = 32'(g);
    return gx[hugt_pkg::GIDX_W-1:0];
  endfunction

  always_comb begin
    if (table_bits < hugt_pkg::TBITS_MIN) begin
      bits_eff = hugt_pkg::TBITS_MIN;
    end else if (32'(table_bits) > SLOT_BITS) begin
      bits_eff = hugt_pkg::TBITS_W'(SLOT_BITS);
    end else begin
      bits_eff = table_bits;
    end
  end

  assign size_in  = (SW+1)'(1) << bits_eff;
  assign mask_in  = SW'(size_in - (SW+1)'(1));
  assign poly_in  = size_in + (SW+1)'(hugt_pkg::POLY_SLACK[{1'b0, bits_eff}]);
  assign mixed_in = HW'($signed(in_hash) >>> 3);
  assign step_raw = SW'(in_hash ^ mixed_in) & mask_in;
  assign step_in  = (step_raw == '0) ? mask_in : step_raw;
  assign probe_in = ~SW'(in_hash) & mask_in;

  logic [SW-1:0] probe_adv;
  logic [SW:0]   step_dbl;
  logic [SW:0]   step_red;
  logic [RW-1:0] m_row;
  logic [HW-1:0] m_hash;
  logic [KEY_WIDTH-1:0] m_key;

  assign probe_adv = (probe_r + step_r) & mask_r;
  assign step_dbl  = {step_r, 1'b0};
  assign step_red  = (step_dbl > {1'b0, mask_r}) ? (step_dbl ^ poly_r) : step_dbl;
  assign {m_row, m_hash, m_key} = grp_rd_data;

  always_comb begin
    state_nxt     = state_r;
    clr_reply_nxt = clr_reply_r;
    sweep_nxt     = sweep_r;
    fill_nxt      = fill_r;
    probe_nxt     = probe_r;
    step_nxt      = step_r;
    visits_nxt    = visits_r;
    size_nxt      = size_r;
    mask_nxt      = mask_r;
    poly_nxt      = poly_r;
    g_nxt         = g_r;
    func_nxt      = func_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    row_nxt       = row_r;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    res_load      = 1'b0;
    slot_rd_en    = 1'b0;
    slot_rd_addr  = probe_adv;
    slot_wr_en    = 1'b0;
    slot_wr_addr  = probe_r;
    slot_wr_data  = fill_r + SW'(1);
    grp_rd_en     = 1'b0;
    grp_rd_addr   = slot_rd_data - SW'(1);
    grp_wr_en     = 1'b0;
    grp_wr_addr   = fill_r;
    grp_wr_data   = {row_r, hash_r, key_r};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt   = in_func;
          hash_nxt   = in_hash;
          key_nxt    = in_key;
          row_nxt    = in_row;
          size_nxt   = size_in;
          mask_nxt   = mask_in;
          poly_nxt   = poly_in;
          step_nxt   = step_in;
          probe_nxt  = probe_in;
          visits_nxt = '0;
          if (in_func == hugt_pkg::FUNC_CLEAR) begin
            fill_nxt      = '0;
            sweep_nxt     = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_SWEEP;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_SWEEP: begin
        slot_wr_en   = 1'b1;
        slot_wr_addr = sweep_r;
        slot_wr_data = '0;
        sweep_nxt    = sweep_r + SW'(1);
        if (sweep_r == '1) begin
          if (clr_reply_r) begin
            res_nxt   = '{status: hugt_pkg::ST_MISS, group_index: '0, group_row: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
          clr_reply_nxt = 1'b0;
        end
      end
      S_PROBE: begin
        if (visits_r >= size_r) begin
          res_nxt   = '{status: hugt_pkg::ST_FULL, group_index: '0, group_row: '0};
          state_nxt = S_DONE;
        end else begin
          slot_rd_en = 1'b1;
          probe_nxt  = probe_adv;
          visits_nxt = visits_r + (SW+1)'(1);
          state_nxt  = S_SLOT;
        end
      end
      S_SLOT: begin
        if (slot_rd_data == '0) begin
          state_nxt = S_DONE;
          if (func_r != hugt_pkg::FUNC_INSERT) begin
            res_nxt = '{status: hugt_pkg::ST_MISS, group_index: '0, group_row: '0};
          end else if ({1'b0, fill_r} >= size_r - (SW+1)'(1)) begin
            res_nxt = '{status: hugt_pkg::ST_FULL, group_index: '0, group_row: '0};
          end else begin
            slot_wr_en = 1'b1;
            grp_wr_en  = 1'b1;
            fill_nxt   = fill_r + SW'(1);
            res_nxt    = '{status: hugt_pkg::ST_INSERTED, group_index: gidx(fill_r),
                           group_row: row_r};
          end
        end else begin
          grp_rd_en = 1'b1;
          g_nxt     = slot_rd_data - SW'(1);
          state_nxt = S_GROUP;
        end
      end
      S_GROUP: begin
        if (m_hash == hash_r && m_key == key_r) begin
          res_nxt   = '{status: hugt_pkg::ST_HIT, group_index: gidx(g_r), group_row: m_row};
          state_nxt = S_DONE;
        end else begin
          step_nxt  = step_red[SW-1:0] & mask_r;
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      clr_reply_r <= 1'b0;
      sweep_r     <= '0;
      fill_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_reply_r <= clr_reply_nxt;
      sweep_r     <= sweep_nxt;
      fill_r      <= fill_nxt;
    end
    probe_r  <= probe_nxt;
    step_r   <= step_nxt;
    visits_r <= visits_nxt;
    size_r   <= size_nxt;
    mask_r   <= mask_nxt;
    poly_r   <= poly_nxt;
    g_r      <= g_nxt;
    func_r   <= func_nxt;
    hash_r   <= hash_nxt;
    key_r    <= key_nxt;
    row_r    <= row_nxt;
    res_r    <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/hash_unique_group_table.sv
// hash_unique_group_table: deduplicating open-addressing hash table engine
//
// channels: in_* takes one item (func in tuser; hash, key, row in tdata),
// out_* returns one result item per input item (status in tuser; group index
// and group row in tdata), cfg_* writes table_bits at any time the block idles.
// an input item is taken only while the sequencer is idle; its result sits in
// an output register, so the next item is taken while that result waits.
// a lookup or insert probes until a probe finds an empty slot, a probe hits,
// or the probe count reaches the table size; each probe is a slot memory read,
// a check of the slot and, for a used slot, a group memory read and compare.
// a clear item sweeps every slot, one per cycle. after reset the same sweep
// runs with in_tready low, and table_bits returns to 10; configuration writes
// are taken throughout.
// when out_tready is low the finished result holds in the output register and
// the sequencer waits before delivering the following one.
// depends on hugt_pkg, hugt_ram, hugt_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hash_unique_group_table #(
  parameter int SLOT_BITS = 10,
  parameter int KEY_WIDTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [119:0] in_tdata,   // key_hash, key_value, row_index, zero pad
  input  wire logic [1:0]   in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // group_index, group_row, zero pad
  output logic [1:0]        out_tuser   // status
);

  localparam int GRP_W = hugt_pkg::ROW_W + hugt_pkg::HASH_W + KEY_WIDTH;

  logic [hugt_pkg::TBITS_W-1:0] table_bits_r;
  logic out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic out_free;
  logic res_load;
  hugt_pkg::result_t res;

  logic                 slot_rd_en, slot_wr_en;
  logic [SLOT_BITS-1:0] slot_rd_addr, slot_wr_addr, slot_rd_data, slot_wr_data;
  logic                 grp_rd_en, grp_wr_en;
  logic [SLOT_BITS-1:0] grp_rd_addr, grp_wr_addr;
  logic [GRP_W-1:0]     grp_rd_data, grp_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_bits_r <= hugt_pkg::TBITS_RESET;
    end else if (cfg_valid) begin
      table_bits_r <= cfg_data;
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (res_load) begin
      out_tdata_r <= {2'b00, res.group_row, res.group_index};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  hugt_ctrl #(
    .SLOT_BITS (SLOT_BITS),
    .KEY_WIDTH (KEY_WIDTH),
    .GRP_W     (GRP_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_func      (in_tuser),
    .in_hash      (in_tdata[31:0]),
    .in_key       (in_tdata[32 +: KEY_WIDTH]),
    .in_row       (in_tdata[115:96]),
    .table_bits   (table_bits_r),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .slot_rd_en   (slot_rd_en),
    .slot_rd_addr (slot_rd_addr),
    .slot_rd_data (slot_rd_data),
    .slot_wr_en   (slot_wr_en),
    .slot_wr_addr (slot_wr_addr),
    .slot_wr_data (slot_wr_data),
    .grp_rd_en    (grp_rd_en),
    .grp_rd_addr  (grp_rd_addr),
    .grp_rd_data  (grp_rd_data),
    .grp_wr_en    (grp_wr_en),
    .grp_wr_addr  (grp_wr_addr),
    .grp_wr_data  (grp_wr_data)
  );

  hugt_ram #(
    .ADDR_W (SLOT_BITS),
    .DATA_W (SLOT_BITS)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  hugt_ram #(
    .ADDR_W (SLOT_BITS),
    .DATA_W (GRP_W)
  ) u_group_ram (
    .clk     (clk),
    .rd_en   (grp_rd_en),
    .rd_addr (grp_rd_addr),
    .rd_data (grp_rd_data),
    .wr_en   (grp_wr_en),
    .wr_addr (grp_wr_addr),
    .wr_data (grp_wr_data)
  );

  // a finished result never overwrites one still waiting
  `ASSERT_IMPLY(a_no_overwrite, clk, rst_n, res_load, !out_tvalid_r || out_tready)
  // a new group record always comes with a nonempty slot entry
  `ASSERT_IMPLY(a_group_with_slot, clk, rst_n, grp_wr_en, slot_wr_en && slot_wr_data != '0)
  // the slot memory is never read and written in one cycle
  `ASSERT_IMPLY(a_slot_port_excl, clk, rst_n, slot_rd_en, !slot_wr_en)
  // an item taken is never answered in the very next cycle
  `ASSERT_NEXT(a_no_instant_reply, clk, rst_n, in_tvalid && in_tready, !res_load)

endmodule

`default_nettype wire

// File: sim/hash_unique_group_table_tb.sv
// testbench for hash_unique_group_table: random and directed lookup, insert and clear items
// checked against an in-bench model of the probing table; depends on hugt_pkg and the rtl
`timescale 1ns / 1ps

module hash_unique_group_table_tb;

  localparam logic [hugt_pkg::FUNC_W-1:0] FUNC_RESERVED = 2'd3;
  localparam int NUM_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_BITS [NUM_PHASES] = '{4, 2, 15, 8, 3, 10, 0, 6, 1, 5};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{120, 120, 150, 130, 110, 150, 80, 130, 60, 150};
  localparam bit PHASE_CLEAR [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1, 0, 0};

  class group_table_sb;
    logic [3:0]  table_bits;
    logic [10:0] slots [NUM_SLOTS];
    logic [19:0] first_row [NUM_SLOTS];
    logic [31:0] grp_hash [NUM_SLOTS];
    logic [63:0] grp_key [NUM_SLOTS];
    int unsigned fill_count;
    hugt_pkg::result_t expected_q [$];
    int unsigned err_count;
    int unsigned status_count [4];

    function new();
      table_bits = hugt_pkg::TBITS_RESET;
      foreach (slots[i]) begin
        slots[i] = '0;
        first_row[i] = '0;
        grp_hash[i] = '0;
        grp_key[i] = '0;
      end
      fill_count = 0;
      err_count = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_table_bits(logic [3:0] v);
      table_bits = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function hugt_pkg::result_t probe_table(logic [1:0] f, logic [31:0] h, logic [63:0] k,
                                            logic [19:0] r);
      hugt_pkg::result_t res;
      int unsigned bits, size, mask, poly, probe, step, visits, g;
      logic [31:0] mixed;
      bit hit, open;
      res = '0;
      res.status = hugt_pkg::ST_MISS;
      if (f == hugt_pkg::FUNC_CLEAR) begin
        foreach (slots[i]) slots[i] = '0;
        fill_count = 0;
        return res;
      end
      bits = (table_bits < hugt_pkg::TBITS_MIN) ? hugt_pkg::TBITS_MIN :
             ((table_bits > 10) ? 10 : table_bits);
      size = 1 << bits;
      mask = size - 1;
      poly = size + hugt_pkg::POLY_SLACK[bits];
      probe = ~h & mask;
      mixed = $signed(h) >>> 3;
      step = (h ^ mixed) & mask;
      if (step == 0) step = mask;
      visits = 0;
      hit = 0;
      open = 0;
      g = 0;
      while (!hit && !open && visits < size) begin
        probe = (probe + step) & mask;
        visits++;
        if (slots[probe] == 0) begin
          open = 1;
        end else begin
          g = slots[probe] - 1;
          if (grp_hash[g] == h && grp_key[g] == k) begin
            hit = 1;
          end else begin
            step = step << 1;
            if (step > mask) step = step ^ poly;
            step = step & mask;
          end
        end
      end
      if (hit) begin
        res.status = hugt_pkg::ST_HIT;
        res.group_index = g[hugt_pkg::GIDX_W-1:0];
        res.group_row = first_row[g];
      end else if (!open) begin
        res.status = hugt_pkg::ST_FULL;
      end else if (f == hugt_pkg::FUNC_INSERT) begin
        if (fill_count >= size - 1) begin
          res.status = hugt_pkg::ST_FULL;
        end else begin
          g = fill_count;
          slots[probe] = 11'(g + 1);
          first_row[g] = r;
          grp_hash[g] = h;
          grp_key[g] = k;
          fill_count = g + 1;
          res.status = hugt_pkg::ST_INSERTED;
          res.group_index = g[hugt_pkg::GIDX_W-1:0];
          res.group_row = r;
        end
      end
      return res;
    endfunction

    function void note_item(logic [1:0] f, logic [31:0] h, logic [63:0] k, logic [19:0] r);
      hugt_pkg::result_t res;
      res = probe_table(f, h, k, r);
      status_count[res.status]++;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [9:0] gi, logic [19:0] gr);
      hugt_pkg::result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no item pending: status %0d group_index %0d group_row %0d",
               st, gi, gr);
        err_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (st !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, st);
          err_count++;
        end
        if (gi !== exp_res.group_index) begin
          $error("group_index expected %0d actual %0d", exp_res.group_index, gi);
          err_count++;
        end
        if (gr !== exp_res.group_row) begin
          $error("group_row expected %0d actual %0d", exp_res.group_row, gr);
          err_count++;
        end
      end
    endfunction
  endclass

  typedef struct {
    logic [31:0] h;
    logic [63:0] k;
  } key_pair_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;   // key_hash, key_value, row_index, zero pad
  logic [1:0]   in_tuser;   // func
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // group_index, group_row, zero pad
  logic [1:0]   out_tuser;  // status

  group_table_sb sb;
  key_pair_t     key_pool [$];
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   settings_used;
  int unsigned   cycle_count;
  int unsigned   sender_idle_pct;
  int unsigned   receiver_idle_pct;
  logic [19:0]   next_row;

  hash_unique_group_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tuser, out_tdata[9:0], out_tdata[29:10]);
        results_seen++;
      end
      if (in_tvalid && in_tready)
        sb.note_item(in_tuser, in_tdata[31:0], in_tdata[95:32], in_tdata[115:96]);
    end
  end

  // receiver side, with one long hold-off so the block backs up
  initial begin
    int unsigned hold;
    bit burst_done;
    hold = 0;
    burst_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!burst_done && results_seen >= 600) begin
        hold = 400;
        burst_done = 1;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results pending", cycle_count, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic [1:0] f, input logic [31:0] h, input logic [63:0] k,
                           input logic [19:0] r);
    if (items_sent < 400) begin
      sender_idle_pct = 26;
      receiver_idle_pct = 59;
    end else if (items_sent < 800) begin
      sender_idle_pct = 59;
      receiver_idle_pct = 26;
    end else begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {4'b0, r, k, h};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_table_bits(input logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_table_bits(v);
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic insert_key(input logic [31:0] h, input logic [63:0] k);
    send_item(hugt_pkg::FUNC_INSERT, h, k, next_row);
    next_row = next_row + 20'd7;
  endtask

  task automatic send_random_item();
    logic [1:0]  f;
    logic [31:0] h;
    logic [63:0] k;
    logic [19:0] r;
    int unsigned roll, pick;
    key_pair_t   kp;
    roll = $urandom_range(999);
    if (roll < 15) f = hugt_pkg::FUNC_CLEAR;
    else if (roll < 95) f = FUNC_RESERVED;
    else if (roll < 450) f = hugt_pkg::FUNC_LOOKUP;
    else f = hugt_pkg::FUNC_INSERT;
    h = $urandom;
    k = {$urandom, $urandom};
    r = 20'($urandom_range(20'hFFFFF));
    pick = $urandom_range(99);
    if (key_pool.size() > 0 && pick < 40) begin
      kp = key_pool[$urandom_range(key_pool.size() - 1)];
      h = kp.h;
      k = kp.k;
    end else if (key_pool.size() > 0 && pick < 55) begin
      h = key_pool[$urandom_range(key_pool.size() - 1)].h;
    end else if (pick < 70) begin
      h = $urandom_range(63);
    end else if (pick < 78) begin
      case ($urandom_range(3))
        0: h = 32'h0000_0000;
        1: h = 32'h7FFF_FFFF;
        2: h = 32'h8000_0000;
        default: h = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(2))
        0: k = '0;
        1: k = '1;
        default: k = 64'h8000_0000_0000_0000;
      endcase
      r = $urandom_range(1) ? 20'hFFFFF : 20'h0;
    end
    if (f == hugt_pkg::FUNC_INSERT) begin
      kp.h = h;
      kp.k = k;
      key_pool.push_back(kp);
      if (key_pool.size() > 256) void'(key_pool.pop_front());
    end
    send_item(f, h, k, r);
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    results_seen = 0;
    settings_used = 1;
    next_row = 20'd100;
    sender_idle_pct = 26;
    receiver_idle_pct = 59;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-size table after reset: extremes, hash collisions, reserved func, clear
    send_item(hugt_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 20'h0);
    send_item(hugt_pkg::FUNC_INSERT, 32'h0, 64'h0, 20'h0);
    send_item(hugt_pkg::FUNC_INSERT, 32'h0, 64'h0, 20'h5);
    send_item(hugt_pkg::FUNC_INSERT, 32'h7FFF_FFFF, '1, 20'hFFFFF);
    send_item(hugt_pkg::FUNC_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 20'h1);
    send_item(hugt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 64'h1, 20'h2);
    send_item(hugt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 64'h2, 20'h3);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h2, 20'h0);
    send_item(FUNC_RESERVED, 32'h7FFF_FFFF, '1, 20'h0);
    send_item(FUNC_RESERVED, 32'h1234_5678, 64'hDEAD_BEEF, 20'h9);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'h1234_5678, 64'hDEAD_BEEF, 20'h0);
    send_item(hugt_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, '1, 20'hFFFFF);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'h0, 64'h0, 20'h0);

    // smallest table: fill to size minus one, then an insert that finds it full
    drain();
    write_table_bits(4'd2);
    send_item(hugt_pkg::FUNC_CLEAR, 32'h0, 64'h0, 20'h0);
    insert_key(32'h0000_00A1, 64'h11);
    insert_key(32'h0000_00B2, 64'h22);
    insert_key(32'h0000_00C3, 64'h33);
    insert_key(32'h0000_00D4, 64'h44);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'h0000_00A1, 64'h11, 20'h0);

    // fill slots 0..3 of an 8-slot table, then shrink so every probe finds a used slot
    drain();
    write_table_bits(4'd3);
    send_item(hugt_pkg::FUNC_CLEAR, 32'h0, 64'h0, 20'h0);
    insert_key(32'd8, 64'd8);
    insert_key(32'd16, 64'd16);
    insert_key(32'd24, 64'd24);
    insert_key(32'd32, 64'd32);
    drain();
    write_table_bits(4'd2);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'd8, 64'd8, 20'h0);
    send_item(hugt_pkg::FUNC_LOOKUP, 32'h55, 64'h55, 20'h0);
    send_item(hugt_pkg::FUNC_INSERT, 32'h55, 64'h55, 20'h66);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_table_bits(4'(PHASE_BITS[p]));
      if (PHASE_CLEAR[p])
        send_item(hugt_pkg::FUNC_CLEAR, $urandom, {$urandom, $urandom},
                  20'($urandom_range(20'hFFFFF)));
      repeat (PHASE_ITEMS[p]) send_random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items over %0d table size settings, receiver hold-off included",
             items_sent, settings_used);
    $display("expected: %0d hits, %0d misses or clears, %0d inserts, %0d full",
             sb.status_count[hugt_pkg::ST_HIT], sb.status_count[hugt_pkg::ST_MISS],
             sb.status_count[hugt_pkg::ST_INSERTED], sb.status_count[hugt_pkg::ST_FULL]);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hugt_pkg.sv
rtl/hugt_ram.sv
rtl/hugt_ctrl.sv
rtl/hash_unique_group_table.sv
sim/hash_unique_group_table_tb.sv
